[rtl/core/hca_pkg.sv]
`default_nettype none
package hca_pkg;

  // component format
  localparam int CW  = 32;
  localparam int FB  = 24;
  localparam int NC  = 4;
  localparam int OPW = 3;
  localparam int STW = 2;

  // operation codes
  localparam logic [OPW-1:0] OP_MUL = 3'd0;
  localparam logic [OPW-1:0] OP_SQR = 3'd1;
  localparam logic [OPW-1:0] OP_INV = 3'd2;
  localparam logic [OPW-1:0] OP_ADD = 3'd3;
  localparam logic [OPW-1:0] OP_SUB = 3'd4;
  localparam logic [OPW-1:0] OP_NEG = 3'd5;

  // status codes
  localparam logic [STW-1:0] ST_OK   = 2'd0;
  localparam logic [STW-1:0] ST_SING = 2'd1;
  localparam logic [STW-1:0] ST_SAT  = 2'd2;

  // intermediate widths
  localparam int PW   = 2 * CW;          // product of two components
  localparam int LW   = CW + 1;          // sum of two components
  localparam int AW   = PW + 2;          // sum of four products
  localparam int MW   = PW + 1;          // modulus, unsigned
  localparam int KW   = PW + 1;          // x*t - y*z
  localparam int K2W  = PW + 2;          // twice that
  localparam int PQW  = PW + 2;          // the two determinant factors
  localparam int HL   = (PQW + 1) / 2;   // low half of a factor
  localparam int HH   = PQW - HL;        // high half of a factor
  localparam int DPW  = 2 * HL;          // partial determinant product
  localparam int DETW = 2 * PQW - 1;     // determinant
  localparam int MHW  = MW - CW;         // high part of modulus
  localparam int KHW  = K2W - CW;        // high part of 2k, signed
  localparam int PLW  = 2 * CW + 1;      // component times low part
  localparam int PMHW = CW + MHW + 1;    // component times modulus high part
  localparam int PKHW = CW + KHW;        // component times 2k high part
  localparam int CMW  = 3 * CW + 1;      // component times modulus or 2k
  localparam int NW   = CMW + 1;         // numerator, signed
  localparam int MAGW = NW - 1;          // numerator magnitude
  localparam int DVW  = MAGW + 2 * FB;   // scaled dividend
  localparam int SHW  = DETW + CW;       // divisor at the top quotient bit
  localparam int RW   = (DVW > SHW) ? DVW : SHW;
  localparam int NDS  = CW + 1;          // range check plus one stage per quotient bit

  typedef struct packed {
    logic [OPW-1:0]         op;
    logic [NC-1:0][CW-1:0]  a;
    logic [NC-1:0][CW-1:0]  b;
  } hca_req_t;

  typedef struct packed {
    logic [NC-1:0][CW-1:0]  r;
    logic [STW-1:0]         status;
  } hca_rsp_t;

  // handoff from the multiply stages to the divider
  typedef struct packed {
    logic [OPW-1:0]          op;
    logic                    sing;
    logic [DETW-1:0]         det;
    logic [NC-1:0][MAGW-1:0] mag;
    logic [NC-1:0]           nneg;
    logic [NC-1:0][CW-1:0]   rsat;
    logic                    rflag;
  } hca_mid_t;

  // one divider stage
  typedef struct packed {
    logic [OPW-1:0]         op;
    logic                   sing;
    logic [DETW-1:0]        det;
    logic [NC-1:0][RW-1:0]  rem;
    logic [NC-1:0][CW-1:0]  q;
    logic [NC-1:0]          ovf;
    logic [NC-1:0]          nneg;
    logic [NC-1:0][CW-1:0]  rsat;
    logic                   rflag;
  } hca_dstg_t;

  // clamp a wide signed value to one component, flag in the top bit
  function automatic logic [CW:0] sat_comp(input logic signed [AW-1:0] v);
    logic signed [AW-1:0] hi;
    logic signed [AW-1:0] lo;
    hi = $signed({{(AW-CW+1){1'b0}}, {(CW-1){1'b1}}});
    lo = $signed({{(AW-CW+1){1'b1}}, {(CW-1){1'b0}}});
    if (v > hi) begin
      return {1'b1, 1'b0, {(CW-1){1'b1}}};
    end else if (v < lo) begin
      return {1'b1, 1'b1, {(CW-1){1'b0}}};
    end else begin
      return {1'b0, v[CW-1:0]};
    end
  endfunction

endpackage
`default_nettype wire

[rtl/core/hca_req_if.sv]
`default_nettype none
interface hca_req_if
  import hca_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [OPW-1:0]        req_type;
  logic signed [CW-1:0]  a_x;
  logic signed [CW-1:0]  a_y;
  logic signed [CW-1:0]  a_z;
  logic signed [CW-1:0]  a_t;
  logic signed [CW-1:0]  b_x;
  logic signed [CW-1:0]  b_y;
  logic signed [CW-1:0]  b_z;
  logic signed [CW-1:0]  b_t;

  modport source (
    output valid, req_type, a_x, a_y, a_z, a_t, b_x, b_y, b_z, b_t,
    input  ready
  );
  modport sink (
    input  valid, req_type, a_x, a_y, a_z, a_t, b_x, b_y, b_z, b_t,
    output ready
  );
endinterface
`default_nettype wire

[rtl/core/hca_rsp_if.sv]
`default_nettype none
interface hca_rsp_if
  import hca_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic signed [CW-1:0]  r_x;
  logic signed [CW-1:0]  r_y;
  logic signed [CW-1:0]  r_z;
  logic signed [CW-1:0]  r_t;
  logic [STW-1:0]        status;

  modport source (
    output valid, r_x, r_y, r_z, r_t, status,
    input  ready
  );
  modport sink (
    input  valid, r_x, r_y, r_z, r_t, status,
    output ready
  );
endinterface
`default_nettype wire

[rtl/core/hca_front.sv]
`default_nettype none
module hca_front
  import hca_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      en_i,
  input  logic      valid_i,
  input  hca_req_t  req_i,
  output logic      valid_o,
  output hca_mid_t  mid_o
);

  localparam logic signed [AW-1:0] RND  = $signed({{(AW-FB){1'b0}}, {FB{1'b1}}});
  localparam logic signed [AW-1:0] ZERO = '0;

  // ---------------- stage 1: component products and linear ops
  logic signed [CW-1:0] a_c [NC];
  logic signed [CW-1:0] b_c [NC];
  logic signed [LW-1:0] lin_d [NC];
  logic signed [PW-1:0] p_d [NC][NC];

  logic                 s1_v_q;
  logic [OPW-1:0]       s1_op_q;
  logic signed [CW-1:0] s1_a_q [NC];
  logic signed [LW-1:0] s1_lin_q [NC];
  logic signed [PW-1:0] s1_p_q [NC][NC];

  always_comb begin
    for (int i = 0; i < NC; i++) begin
      a_c[i] = $signed(req_i.a[i]);
      // square and inverse multiply A by itself
      b_c[i] = (req_i.op == OP_MUL) ? $signed(req_i.b[i]) : a_c[i];
      case (req_i.op)
        OP_ADD: begin
          lin_d[i] = LW'(a_c[i]) + LW'($signed(req_i.b[i]));
        end
        OP_SUB: begin
          lin_d[i] = LW'(a_c[i]) - LW'($signed(req_i.b[i]));
        end
        OP_NEG: begin
          lin_d[i] = -LW'(a_c[i]);
        end
        default: begin
          lin_d[i] = '0;
        end
      endcase
    end
    for (int i = 0; i < NC; i++) begin
      for (int j = 0; j < NC; j++) begin
        p_d[i][j] = a_c[i] * b_c[j];
      end
    end
  end

  // ---------------- stage 2: product sums, modulus and k
  logic signed [AW-1:0] acc_d [NC];
  logic signed [AW-1:0] msum;
  logic [MW-1:0]        mod_d;
  logic signed [KW-1:0] k_d;

  logic                 s2_v_q;
  logic [OPW-1:0]       s2_op_q;
  logic signed [CW-1:0] s2_a_q [NC];
  logic signed [AW-1:0] s2_acc_q [NC];
  logic [MW-1:0]        s2_mod_q;
  logic signed [KW-1:0] s2_k_q;

  always_comb begin
    case (s1_op_q)
      OP_MUL, OP_SQR: begin
        acc_d[0] = AW'(s1_p_q[0][0]) - AW'(s1_p_q[1][1])
                 - AW'(s1_p_q[2][2]) + AW'(s1_p_q[3][3]);
        acc_d[1] = AW'(s1_p_q[1][0]) + AW'(s1_p_q[0][1])
                 - AW'(s1_p_q[3][2]) - AW'(s1_p_q[2][3]);
        acc_d[2] = AW'(s1_p_q[2][0]) - AW'(s1_p_q[3][1])
                 + AW'(s1_p_q[0][2]) - AW'(s1_p_q[1][3]);
        acc_d[3] = AW'(s1_p_q[3][0]) + AW'(s1_p_q[2][1])
                 + AW'(s1_p_q[1][2]) + AW'(s1_p_q[0][3]);
      end
      OP_ADD, OP_SUB, OP_NEG: begin
        for (int i = 0; i < NC; i++) begin
          acc_d[i] = AW'(s1_lin_q[i]);
        end
      end
      default: begin
        for (int i = 0; i < NC; i++) begin
          acc_d[i] = ZERO;
        end
      end
    endcase
    msum  = AW'(s1_p_q[0][0]) + AW'(s1_p_q[1][1]) + AW'(s1_p_q[2][2]) + AW'(s1_p_q[3][3]);
    mod_d = msum[MW-1:0];
    k_d   = KW'(s1_p_q[0][3]) - KW'(s1_p_q[1][2]);
  end

  // ---------------- stage 3: determinant factors, numerator partials, rescale
  logic signed [K2W-1:0]  k2s;
  logic signed [PQW:0]    pe;
  logic signed [PQW:0]    qe;
  logic [CW-1:0]          ml;
  logic [MHW-1:0]         mh;
  logic [CW-1:0]          kl;
  logic signed [KHW-1:0]  kh;
  logic signed [AW-1:0]   rnd;
  logic signed [AW-1:0]   res_d [NC];
  logic signed [PLW-1:0]  pml_d [NC];
  logic signed [PMHW-1:0] pmh_d [NC];
  logic signed [PLW-1:0]  pkl_d [NC];
  logic signed [PKHW-1:0] pkh_d [NC];

  logic                   s3_v_q;
  logic [OPW-1:0]         s3_op_q;
  logic [PQW-1:0]         s3_p_q;
  logic [PQW-1:0]         s3_q_q;
  logic signed [AW-1:0]   s3_res_q [NC];
  logic signed [PLW-1:0]  s3_pml_q [NC];
  logic signed [PMHW-1:0] s3_pmh_q [NC];
  logic signed [PLW-1:0]  s3_pkl_q [NC];
  logic signed [PKHW-1:0] s3_pkh_q [NC];

  always_comb begin
    k2s = $signed({s2_k_q, 1'b0});
    // (x-t)^2+(y+z)^2 = mod - 2k, (x+t)^2+(y-z)^2 = mod + 2k
    pe  = $signed({2'b00, s2_mod_q}) - (PQW+1)'(k2s);
    qe  = $signed({2'b00, s2_mod_q}) + (PQW+1)'(k2s);
    ml  = s2_mod_q[CW-1:0];
    mh  = s2_mod_q[MW-1:CW];
    kl  = k2s[CW-1:0];
    kh  = $signed(k2s[K2W-1:CW]);
    rnd = ZERO;
    for (int i = 0; i < NC; i++) begin
      pml_d[i] = s2_a_q[i] * $signed({1'b0, ml});
      pmh_d[i] = s2_a_q[i] * $signed({1'b0, mh});
      pkl_d[i] = s2_a_q[i] * $signed({1'b0, kl});
      pkh_d[i] = s2_a_q[i] * kh;
      // drop fraction bits, rounding toward zero
      rnd = s2_acc_q[i] + (s2_acc_q[i][AW-1] ? RND : ZERO);
      if (s2_op_q == OP_MUL || s2_op_q == OP_SQR) begin
        res_d[i] = rnd >>> FB;
      end else begin
        res_d[i] = s2_acc_q[i];
      end
    end
  end

  // ---------------- stage 4: determinant partials, numerators, clamp
  logic [HL-1:0]          pl;
  logic [HH-1:0]          ph;
  logic [HL-1:0]          ql;
  logic [HH-1:0]          qh;
  logic [DPW-1:0]         dll_d;
  logic [DPW-1:0]         dlh_d;
  logic [DPW-1:0]         dhl_d;
  logic [DPW-1:0]         dhh_d;
  logic signed [CMW-1:0]  cm [NC];
  logic signed [CMW-1:0]  ck [NC];
  logic signed [NW-1:0]   n_d [NC];
  logic [CW:0]            sc [NC];
  logic [NC-1:0][CW-1:0]  rsat_d;
  logic                   rflag_d;

  logic                   s4_v_q;
  logic [OPW-1:0]         s4_op_q;
  logic                   s4_sing_q;
  logic [DPW-1:0]         s4_dll_q;
  logic [DPW-1:0]         s4_dlh_q;
  logic [DPW-1:0]         s4_dhl_q;
  logic [DPW-1:0]         s4_dhh_q;
  logic signed [NW-1:0]   s4_n_q [NC];
  logic [NC-1:0][CW-1:0]  s4_rsat_q;
  logic                   s4_rflag_q;

  always_comb begin
    pl    = s3_p_q[HL-1:0];
    ph    = s3_p_q[PQW-1:HL];
    ql    = s3_q_q[HL-1:0];
    qh    = s3_q_q[PQW-1:HL];
    dll_d = pl * ql;
    dlh_d = pl * qh;
    dhl_d = ph * ql;
    dhh_d = ph * qh;
    rflag_d = 1'b0;
    for (int i = 0; i < NC; i++) begin
      cm[i] = (CMW'(s3_pmh_q[i]) <<< CW) + CMW'(s3_pml_q[i]);
      ck[i] = (CMW'(s3_pkh_q[i]) <<< CW) + CMW'(s3_pkl_q[i]);
      sc[i] = sat_comp(s3_res_q[i]);
      rsat_d[i] = sc[i][CW-1:0];
      rflag_d = rflag_d | sc[i][CW];
    end
    n_d[0] =  NW'(cm[0]) - NW'(ck[3]);
    n_d[1] = -NW'(cm[1]) - NW'(ck[2]);
    n_d[2] = -NW'(cm[2]) - NW'(ck[1]);
    n_d[3] =  NW'(cm[3]) - NW'(ck[0]);
  end

  // ---------------- stage 5: determinant sum and numerator magnitudes
  hca_mid_t mid_d;
  hca_mid_t s5_q;
  logic     s5_v_q;

  always_comb begin
    mid_d.op    = s4_op_q;
    mid_d.sing  = s4_sing_q;
    mid_d.det   = (DETW'(s4_dhh_q) << (2 * HL))
                + ((DETW'(s4_dhl_q) + DETW'(s4_dlh_q)) << HL)
                + DETW'(s4_dll_q);
    mid_d.rsat  = s4_rsat_q;
    mid_d.rflag = s4_rflag_q;
    for (int i = 0; i < NC; i++) begin
      mid_d.nneg[i] = s4_n_q[i][NW-1];
      mid_d.mag[i]  = s4_n_q[i][NW-1] ? MAGW'(-s4_n_q[i]) : MAGW'(s4_n_q[i]);
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
      s4_v_q <= 1'b0;
      s5_v_q <= 1'b0;
    end else if (en_i) begin
      s1_v_q <= valid_i;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
      s4_v_q <= s3_v_q;
      s5_v_q <= s4_v_q;
    end
  end

  // stage payloads
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_op_q   <= req_i.op;
      s2_op_q   <= s1_op_q;
      s2_mod_q  <= mod_d;
      s2_k_q    <= k_d;
      s3_op_q   <= s2_op_q;
      s3_p_q    <= pe[PQW-1:0];
      s3_q_q    <= qe[PQW-1:0];
      s4_op_q   <= s3_op_q;
      s4_sing_q <= (s3_p_q == '0) || (s3_q_q == '0);
      s4_dll_q  <= dll_d;
      s4_dlh_q  <= dlh_d;
      s4_dhl_q  <= dhl_d;
      s4_dhh_q  <= dhh_d;
      s4_rsat_q <= rsat_d;
      s4_rflag_q <= rflag_d;
      s5_q      <= mid_d;
      for (int i = 0; i < NC; i++) begin
        s1_a_q[i]   <= a_c[i];
        s1_lin_q[i] <= lin_d[i];
        for (int j = 0; j < NC; j++) begin
          s1_p_q[i][j] <= p_d[i][j];
        end
        s2_a_q[i]   <= s1_a_q[i];
        s2_acc_q[i] <= acc_d[i];
        s3_res_q[i] <= res_d[i];
        s3_pml_q[i] <= pml_d[i];
        s3_pmh_q[i] <= pmh_d[i];
        s3_pkl_q[i] <= pkl_d[i];
        s3_pkh_q[i] <= pkh_d[i];
        s4_n_q[i]   <= n_d[i];
      end
    end
  end

  assign valid_o = s5_v_q;
  assign mid_o   = s5_q;

endmodule
`default_nettype wire

[rtl/core/hca_div.sv]
`default_nettype none
module hca_div
  import hca_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       en_i,
  input  logic       valid_i,
  input  hca_mid_t   mid_i,
  output logic       valid_o,
  output hca_dstg_t  dstg_o
);

  logic [NDS-1:0] st_v_q;
  hca_dstg_t      st_q [NDS];
  hca_dstg_t      st_d [NDS];

  // range check, then one restoring step per quotient bit, msb first
  always_comb begin
    logic [RW-1:0] dsh;
    logic          geq;
    st_d[0].op    = mid_i.op;
    st_d[0].sing  = mid_i.sing;
    st_d[0].det   = mid_i.det;
    st_d[0].nneg  = mid_i.nneg;
    st_d[0].rsat  = mid_i.rsat;
    st_d[0].rflag = mid_i.rflag;
    dsh = RW'(mid_i.det) << CW;
    for (int i = 0; i < NC; i++) begin
      st_d[0].rem[i] = RW'(mid_i.mag[i]) << (2 * FB);
      st_d[0].q[i]   = '0;
      // quotient would not fit in CW bits
      st_d[0].ovf[i] = (st_d[0].rem[i] >= dsh);
    end
    for (int k = 1; k < NDS; k++) begin
      st_d[k] = st_q[k-1];
      dsh = RW'(st_q[k-1].det) << (CW - k);
      for (int i = 0; i < NC; i++) begin
        geq = (st_q[k-1].rem[i] >= dsh);
        st_d[k].rem[i] = geq ? (st_q[k-1].rem[i] - dsh) : st_q[k-1].rem[i];
        st_d[k].q[i]   = {st_q[k-1].q[i][CW-2:0], geq};
      end
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_v_q <= '0;
    end else if (en_i) begin
      st_v_q <= {st_v_q[NDS-2:0], valid_i};
    end
  end

  // stage payloads
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < NDS; k++) begin
        st_q[k] <= st_d[k];
      end
    end
  end

  assign valid_o = st_v_q[NDS-1];
  assign dstg_o  = st_q[NDS-1];

endmodule
`default_nettype wire

[rtl/core/hca_out.sv]
`default_nettype none
module hca_out
  import hca_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  input  hca_dstg_t  dstg_i,
  input  logic       rsp_ready_i,
  output logic       en_o,
  output logic       rsp_valid_o,
  output hca_rsp_t   rsp_o
);

  localparam logic [CW-1:0] MAXV = {1'b0, {(CW-1){1'b1}}};
  localparam logic [CW-1:0] MINV = {1'b1, {(CW-1){1'b0}}};

  hca_rsp_t res;
  logic     ov_q;
  logic     ov_d;
  hca_rsp_t od_q;
  hca_rsp_t od_d;
  logic     sk_v_q;
  logic     sk_v_d;
  hca_rsp_t sk_q;
  hca_rsp_t sk_d;
  logic     take;
  logic     out_free;

  // sign and clamp the quotients, pick the result word
  always_comb begin
    logic [CW-1:0] q;
    logic          big;
    logic          isat;
    logic [NC-1:0][CW-1:0] iv;
    isat = 1'b0;
    for (int i = 0; i < NC; i++) begin
      q = dstg_i.q[i];
      if (dstg_i.nneg[i]) begin
        big   = dstg_i.ovf[i] | (q[CW-1] & (|q[CW-2:0]));
        iv[i] = big ? MINV : (-q);
      end else begin
        big   = dstg_i.ovf[i] | q[CW-1];
        iv[i] = big ? MAXV : q;
      end
      isat = isat | big;
    end
    if (dstg_i.op == OP_INV) begin
      if (dstg_i.sing) begin
        res.r      = '0;
        res.status = ST_SING;
      end else begin
        res.r      = iv;
        res.status = isat ? ST_SAT : ST_OK;
      end
    end else begin
      res.r      = dstg_i.rsat;
      res.status = dstg_i.rflag ? ST_SAT : ST_OK;
    end
  end

  // output register with skid stage; pipeline moves while skid is empty
  always_comb begin
    en_o     = !sk_v_q;
    take     = valid_i && en_o;
    out_free = !ov_q || rsp_ready_i;
    ov_d     = ov_q;
    od_d     = od_q;
    sk_v_d   = sk_v_q;
    sk_d     = sk_q;
    if (out_free) begin
      if (sk_v_q) begin
        ov_d   = 1'b1;
        od_d   = sk_q;
        sk_v_d = 1'b0;
      end else if (take) begin
        ov_d = 1'b1;
        od_d = res;
      end else begin
        ov_d = 1'b0;
      end
    end else if (take) begin
      sk_v_d = 1'b1;
      sk_d   = res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q   <= 1'b0;
      sk_v_q <= 1'b0;
    end else begin
      ov_q   <= ov_d;
      sk_v_q <= sk_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    od_q <= od_d;
    sk_q <= sk_d;
  end

  assign rsp_valid_o = ov_q;
  assign rsp_o       = od_q;

`ifndef SYNTHESIS
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sk_v_q |-> ov_q)
    else $error("skid holds a word while the output register is empty");

  a_skid_fill_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(sk_v_q) |-> $past(ov_q && !rsp_ready_i))
    else $error("skid filled without an output stall");

  a_sing_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && od_q.status == ST_SING) |-> (od_q.r == '0))
    else $error("singular inverse with nonzero result");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q |-> (od_q.status == ST_OK || od_q.status == ST_SING || od_q.status == ST_SAT))
    else $error("undefined status code");
`endif

endmodule
`default_nettype wire

[rtl/core/hypercomplex_arith_unit.sv]
// Arithmetic unit for four-component commutative hypercomplex numbers.
// Input channel req_i carries req_type (multiply, square, inverse, add,
// subtract, negate) and operands A, B as signed Q8.24 components; B is
// used by multiply, add and subtract only. Output channel rsp_o carries
// the four result components and a status word: ok, singular inverse
// (result zero) or saturated.
// Both channels use valid/ready; a word moves when both are high.
// All operations share one path from the accepting edge to rsp_o.valid:
// five multiply and sum stages, a range check stage and one restoring
// divider stage per quotient bit (32), then the output register.
// Fully pipelined, one word per cycle while the receiver takes every word.
// When the receiver stalls, one further word is caught in a skid stage and
// req_i.ready drops the cycle after; no word is lost or repeated.
// Reset (rst_ni low, asynchronous) empties the pipeline and the output.
`default_nettype none
module hypercomplex_arith_unit
  import hca_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  hca_req_if.sink          req_i,
  hca_rsp_if.source        rsp_o
);

  hca_req_t  req;
  hca_mid_t  mid;
  hca_dstg_t dstg;
  hca_rsp_t  rsp;
  logic      en;
  logic      mid_v;
  logic      dstg_v;

  assign req.op   = req_i.req_type;
  assign req.a[0] = req_i.a_x;
  assign req.a[1] = req_i.a_y;
  assign req.a[2] = req_i.a_z;
  assign req.a[3] = req_i.a_t;
  assign req.b[0] = req_i.b_x;
  assign req.b[1] = req_i.b_y;
  assign req.b[2] = req_i.b_z;
  assign req.b[3] = req_i.b_t;
  assign req_i.ready = en;

  hca_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (req_i.valid),
    .req_i   (req),
    .valid_o (mid_v),
    .mid_o   (mid)
  );

  hca_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (mid_v),
    .mid_i   (mid),
    .valid_o (dstg_v),
    .dstg_o  (dstg)
  );

  hca_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (dstg_v),
    .dstg_i      (dstg),
    .rsp_ready_i (rsp_o.ready),
    .en_o        (en),
    .rsp_valid_o (rsp_o.valid),
    .rsp_o       (rsp)
  );

  assign rsp_o.r_x    = rsp.r[0];
  assign rsp_o.r_y    = rsp.r[1];
  assign rsp_o.r_z    = rsp.r[2];
  assign rsp_o.r_t    = rsp.r[3];
  assign rsp_o.status = rsp.status;

endmodule
`default_nettype wire
